/* rtl/csrs_pkg.sv */
// ============================================================================
// csrs_pkg - shared types and constants of the cross stencil relaxation sweep
// Value formats, line bank roles, result kinds and the saturating magnitude.
// ============================================================================
package csrs_pkg;

    // grid geometry
    localparam int MAX_GRID   = 256;
    localparam int MIN_GRID   = 6;
    localparam int COL_BITS   = $clog2(MAX_GRID);
    localparam int SIZE_BITS  = 9;

    // sample format, signed Q15.16
    localparam int VALUE_BITS = 32;
    localparam int SUM4_BITS  = VALUE_BITS + 2;
    localparam int SUM8_BITS  = VALUE_BITS + 3;

    // four row banks, one per row modulo four
    localparam int BANKS      = 4;
    localparam int BANK_BITS  = 2;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [VALUE_BITS-2:0]        resid_t;
    typedef logic [COL_BITS-1:0]          pos_t;
    typedef logic [SIZE_BITS-1:0]         size_t;
    typedef logic [BANK_BITS-1:0]         bank_t;

    localparam resid_t SAT_MAX = {(VALUE_BITS-1){1'b1}};

    // role of a bank relative to the row of the incoming sample
    localparam bank_t ROLE_UP2 = 2'd0;   // row r-4, also takes the write of row r
    localparam bank_t ROLE_UP1 = 2'd1;   // row r-3
    localparam bank_t ROLE_CEN = 2'd2;   // row r-2, centre row
    localparam bank_t ROLE_DN1 = 2'd3;   // row r-1

    // result kinds
    localparam logic KIND_CELL     = 1'b0;
    localparam logic KIND_RESIDUAL = 1'b1;

    // per-bank memory request
    typedef struct packed {
        logic   we;
        logic   re;
        pos_t   waddr;
        pos_t   raddr;
        value_t wdata;
    } ram_req_t;

    // control and sample of one accepted word, as it enters the datapath
    typedef struct packed {
        logic   valid;
        bank_t  bank;
        logic   emit;
        logic   ring1;
        logic   last;
        logic   pre;
        pos_t   row;
        pos_t   col;
        value_t x;
    } ctrl_t;

    // what travels with a word down the datapath
    typedef struct packed {
        logic emit;
        logic last;
        pos_t row;
        pos_t col;
    } tag_t;

    // one result word
    typedef struct packed {
        logic   kind;
        pos_t   row;
        pos_t   col;
        value_t value;
    } result_t;

    // |d| saturated to the largest positive value
    function automatic resid_t abs_sat(input logic signed [VALUE_BITS:0] d);
        logic signed [VALUE_BITS:0] mag;
        logic        [VALUE_BITS:0] umag;
        mag  = d[VALUE_BITS] ? -d : d;
        umag = mag;
        if (umag > {2'b00, SAT_MAX})
            return SAT_MAX;
        else
            return umag[VALUE_BITS-2:0];
    endfunction

endpackage

/* rtl/csrs_ram.sv */
// ============================================================================
// csrs_ram - simple dual port row bank
// One write and one registered read per cycle; a read of the entry being
// written returns the old contents.
// ============================================================================
module csrs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/csrs_seq.sv */
// ============================================================================
// csrs_seq - raster position tracker and bank address generation
// Holds the grid size and the position of the next sample, classifies each
// word and drives the four row banks.
// ============================================================================
module csrs_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               adv,
    input  csrs_pkg::value_t   x,
    input  logic               cfg_wen,
    input  csrs_pkg::size_t    cfg_wdata,
    output csrs_pkg::ram_req_t req [csrs_pkg::BANKS],
    output csrs_pkg::ctrl_t    p1
);
    import csrs_pkg::*;

    size_t grid_reg;
    pos_t  row_reg, row_next;
    pos_t  col_reg, col_next;
    ctrl_t p1_reg, p1_next;

    size_t n;
    size_t r9, c9;
    pos_t  r, c;
    logic  wrap;
    logic  in_ring, on_ring1, pre, last;
    pos_t  cen_addr, pre_addr;
    size_t pre_diff;

    // effective size, clamped into the supported range
    always_comb
    begin
        if (grid_reg < size_t'(MIN_GRID))
            n = size_t'(MIN_GRID);
        else if (grid_reg > size_t'(MAX_GRID))
            n = size_t'(MAX_GRID);
        else
            n = grid_reg;
    end

    // classify the incoming position
    always_comb
    begin
        wrap = ({1'b0, row_reg} >= n) || ({1'b0, col_reg} >= n);
        r    = wrap ? '0 : row_reg;
        c    = wrap ? '0 : col_reg;
        r9   = {1'b0, r};
        c9   = {1'b0, c};

        in_ring  = (r9 >= 9'd1) && (r9 <= n - 9'd2) && (c9 >= 9'd1) && (c9 <= n - 9'd2);
        on_ring1 = in_ring && ((r9 == 9'd1) || (r9 == n - 9'd2) ||
                               (c9 == 9'd1) || (c9 == n - 9'd2));
        pre      = (c9 >= n - 9'd2);
        last     = (r9 == n - 9'd1) && (c9 == n - 9'd1);

        // centre row is read two columns ahead; the last two columns of a
        // row fetch the first two columns of the next centre row instead
        cen_addr = c + pos_t'(2);
        pre_diff = c9 - (n - 9'd2);
        pre_addr = pre_diff[COL_BITS-1:0];
    end

    // bank requests, by role relative to the current row
    always_comb
    begin
        bank_t role;
        for (int k = 0; k < BANKS; k++)
        begin
            role         = bank_t'(k) - r[BANK_BITS-1:0];
            req[k].re    = accept;
            req[k].we    = accept && (role == ROLE_UP2);
            req[k].waddr = c;
            req[k].wdata = x;
            case (role)
                ROLE_UP2: req[k].raddr = c;
                ROLE_UP1: req[k].raddr = c;
                ROLE_CEN: req[k].raddr = cen_addr;
                ROLE_DN1: req[k].raddr = pre ? pre_addr : c;
                default:  req[k].raddr = c;
            endcase
        end
    end

    // next position
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_wen)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (c9 == n - 9'd1)
            begin
                row_next = r + pos_t'(1);
                col_next = '0;
            end
            else
            begin
                row_next = r;
                col_next = c + pos_t'(1);
            end
        end
    end

    // word entering the datapath, lines up with the bank read data
    always_comb
    begin
        p1_next = p1_reg;
        if (adv)
        begin
            p1_next.valid = accept;
            p1_next.bank  = r[BANK_BITS-1:0];
            p1_next.emit  = (r9 >= 9'd4) && (c9 >= 9'd2) && (c9 <= n - 9'd3);
            p1_next.ring1 = on_ring1;
            p1_next.last  = last;
            p1_next.pre   = pre;
            p1_next.row   = r - pos_t'(2);
            p1_next.col   = c;
            p1_next.x     = x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= size_t'(MAX_GRID);
            row_reg  <= '0;
            col_reg  <= '0;
            p1_reg   <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                grid_reg <= cfg_wdata;
            end
            row_reg <= row_next;
            col_reg <= col_next;
            p1_reg  <= p1_next;
        end
    end

    assign p1 = p1_reg;

endmodule

/* rtl/csrs_datapath.sv */
// ============================================================================
// csrs_datapath - stencil arithmetic, residual tracking and result register
// Shifts the centre window, sums the cross, shifts by three, forms the
// residuals and keeps the running maximum; the whole pipe moves on adv.
// ============================================================================
module csrs_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              cfg_wen,
    input  csrs_pkg::ctrl_t   p1,
    input  csrs_pkg::value_t  rdata [csrs_pkg::BANKS],
    output logic              out_valid,
    output csrs_pkg::result_t result
);
    import csrs_pkg::*;

    typedef logic signed [SUM4_BITS-1:0] sum4_t;
    typedef logic signed [SUM8_BITS-1:0] sum8_t;

    function automatic sum4_t ext4(input value_t a);
        return {{(SUM4_BITS-VALUE_BITS){a[VALUE_BITS-1]}}, a};
    endfunction

    // centre window
    value_t  win_reg [5];

    // stage valids
    logic    p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic    out_valid_reg;
    resid_t  resmax_reg, resmax_next;

    // stage payloads
    tag_t    p2_tag_reg, p3_tag_reg, p4_tag_reg;
    sum4_t   p2_vsum_reg, p2_hsum_reg;
    value_t  p2_old_reg, p3_old_reg;
    resid_t  p2_ring_reg, p3_ring_reg, p4_ring_reg;
    value_t  p3_nv_reg, p4_nv_reg;
    resid_t  p4_cell_reg;
    result_t out_reg;

    bank_t   bi_up1, bi_cen, bi_dn1;
    value_t  up2, up1, cen, dn1, shift_in;
    sum8_t   sum8;
    resid_t  m3;

    // pick the bank words by role
    always_comb
    begin
        bi_up1   = p1.bank + ROLE_UP1;
        bi_cen   = p1.bank + ROLE_CEN;
        bi_dn1   = p1.bank + ROLE_DN1;
        up2      = rdata[p1.bank];
        up1      = rdata[bi_up1];
        cen      = rdata[bi_cen];
        dn1      = rdata[bi_dn1];
        shift_in = p1.pre ? dn1 : cen;
    end

    // full sum of the cross; the arithmetic shift by three is taken where it is registered
    always_comb
    begin
        sum8 = {p2_vsum_reg[SUM4_BITS-1], p2_vsum_reg} + {p2_hsum_reg[SUM4_BITS-1], p2_hsum_reg};
    end

    // running maximum over this word's residuals
    always_comb
    begin
        m3 = resmax_reg;
        if (p4_cell_reg > m3)
            m3 = p4_cell_reg;
        if (p4_ring_reg > m3)
            m3 = p4_ring_reg;
        resmax_next = resmax_reg;
        if (cfg_wen)
            resmax_next = '0;
        else if (adv && p4_valid_reg)
            resmax_next = p4_tag_reg.last ? '0 : m3;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            resmax_reg    <= '0;
            for (int k = 0; k < 5; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            resmax_reg <= resmax_next;
            if (adv)
            begin
                p2_valid_reg  <= p1.valid;
                p3_valid_reg  <= p2_valid_reg;
                p4_valid_reg  <= p3_valid_reg;
                out_valid_reg <= p4_valid_reg && (p4_tag_reg.emit || p4_tag_reg.last);
                if (p1.valid)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        win_reg[k] <= win_reg[k+1];
                    end
                    win_reg[4] <= shift_in;
                end
            end
        end
    end

    // payload pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // vertical and horizontal partial sums, old centre value
            p2_tag_reg  <= '{emit: p1.emit, last: p1.last, row: p1.row, col: p1.col};
            p2_vsum_reg <= ext4(up2) + ext4(up1) + ext4(dn1) + ext4(p1.x);
            p2_hsum_reg <= ext4(win_reg[1]) + ext4(win_reg[2]) + ext4(win_reg[4]) + ext4(shift_in);
            p2_old_reg  <= win_reg[3];
            p2_ring_reg <= p1.ring1 ? abs_sat({p1.x[VALUE_BITS-1], p1.x}) : '0;

            // new value, floor of sum over eight
            p3_tag_reg  <= p2_tag_reg;
            p3_nv_reg   <= sum8[SUM8_BITS-1:3];
            p3_old_reg  <= p2_old_reg;
            p3_ring_reg <= p2_ring_reg;

            // interior residual
            p4_tag_reg  <= p3_tag_reg;
            p4_nv_reg   <= p3_nv_reg;
            p4_cell_reg <= p3_tag_reg.emit ?
                           abs_sat({p3_old_reg[VALUE_BITS-1], p3_old_reg} -
                                   {p3_nv_reg[VALUE_BITS-1], p3_nv_reg}) : '0;
            p4_ring_reg <= p3_ring_reg;

            // result word
            if (p4_tag_reg.last)
            begin
                out_reg.kind  <= KIND_RESIDUAL;
                out_reg.row   <= '0;
                out_reg.col   <= '0;
                out_reg.value <= {1'b0, m3};
            end
            else
            begin
                out_reg.kind  <= KIND_CELL;
                out_reg.row   <= p4_tag_reg.row;
                out_reg.col   <= p4_tag_reg.col;
                out_reg.value <= p4_nv_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

/* rtl/cross_stencil_relaxation_sweep_core.sv */
// ============================================================================
// cross_stencil_relaxation_sweep_core - radius-2 cross stencil sweep
// Streams one grid sweep in raster order and returns relaxed interior cells
// followed by the largest residual of the sweep.
// ============================================================================
// The block takes one signed Q15.16 sample per cycle unless the result side
// stalls, and returns each relaxed interior cell once the sample two rows below
// it has passed the entry, sum, new value, residual and result registers; the
// residual maximum word follows the sweep's last sample likewise. The rate
// is set by the four row banks of 256 words, each with one read and one write
// port per cycle: every sample reads one word from each bank and writes itself
// into one. A result stall holds the whole pipe and drops s_tready. The banks
// are not cleared after reset; every entry feeding an emitted word in a well
// formed sweep was written earlier in it. Writing grid_size restarts the sweep.
module cross_stencil_relaxation_sweep_core (
    input  logic                    clk,
    input  logic                    rst_n,
    // sample input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // [31:0] old_value
    // result output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [47:0]             m_tdata,   // [7:0] cell_row, [15:8] cell_col,
                                               // [47:16] result_value
    output logic [0:0]              m_tuser,   // [0] result_kind
    // grid_size register
    input  logic                    cfg_wen,
    input  logic [csrs_pkg::SIZE_BITS-1:0] cfg_wdata
);
    import csrs_pkg::*;

    logic     adv, accept;
    ram_req_t req [BANKS];
    value_t   rdata [BANKS];
    ctrl_t    p1;
    logic     out_valid;
    result_t  result;

    // the pipe moves whenever the result register can take a word
    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    csrs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .adv       (adv),
        .x         (value_t'(s_tdata)),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .p1        (p1)
    );

    // row banks, one per row modulo four
    for (genvar k = 0; k < BANKS; k++)
    begin : g_bank
        csrs_ram #(
            .DEPTH (MAX_GRID),
            .WIDTH (VALUE_BITS)
        ) u_bank (
            .clk   (clk),
            .we    (req[k].we),
            .waddr (req[k].waddr),
            .wdata (req[k].wdata),
            .re    (req[k].re),
            .raddr (req[k].raddr),
            .rdata (rdata[k])
        );
    end

    csrs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg_wen   (cfg_wen),
        .p1        (p1),
        .rdata     (rdata),
        .out_valid (out_valid),
        .result    (result)
    );

    assign m_tvalid   = out_valid;
    assign m_tdata    = {result.value, result.col, result.row};
    assign m_tuser[0] = result.kind;

endmodule

/* rtl/csrs_checker.sv */
// ============================================================================
// csrs_checker - port level checks of the relaxation sweep core
// Watches the result channel and its coupling to the sample channel.
// ============================================================================
module csrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a stalled result side stops sample intake
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("sample taken while result side stalled");

    // residual word carries no position and is never negative
    a_resid_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[15:0] == 16'd0) && !m_tdata[47])
        else $error("malformed residual word");

    // relaxed cells lie at row two or more and column two or more
    a_cell_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[7:0] >= 8'd2) && (m_tdata[15:8] >= 8'd2))
        else $error("cell outside the interior");

endmodule

bind cross_stencil_relaxation_sweep_core csrs_checker u_csrs_checker (.*);
